// ===== hdl/fpsc_pkg.sv =====
// shared types and constants of the free partition sort and coalesce block
`timescale 1ns / 1ps

package fpsc_pkg;

    localparam int ID_W      = 16;
    localparam int ADDR_W    = 32;
    localparam int SIZE_W    = 32;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SORT_BY_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MERGE_ENABLE = 2'd1;

    // one stored free partition
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
    } part_t;

    // control of one sorted chain
    typedef struct packed {
        logic ins;
        logic pop;
    } chain_ctrl_t;

    // control of the emit and coalesce stage
    typedef struct packed {
        logic pop;
        logic first;
        logic last_pop;
        logic merge_mode;
        logic flush;
    } emit_ctrl_t;

endpackage

// ===== hdl/fpsc_cell.sv =====
// one compare-and-shift cell of a sorted partition chain
`timescale 1ns / 1ps

module fpsc_cell
    import fpsc_pkg::*;
#(
    parameter bit BY_SIZE = 1'b0
)
(
    input  logic        clk,
    input  chain_ctrl_t ctrl,
    input  logic        occupied,
    input  part_t       new_part,
    input  part_t       prev_part,
    input  logic        prev_gt,
    input  part_t       next_part,
    output part_t       part,
    output logic        gt
);

    part_t part_reg;
    part_t part_next;
    logic [SIZE_W-1:0] own_key;
    logic [SIZE_W-1:0] new_key;

    // key of the held and the arriving partition
    assign own_key = BY_SIZE ? part_reg.size : part_reg.addr;
    assign new_key = BY_SIZE ? new_part.size : new_part.addr;

    // an empty cell or a strictly larger key marks the insertion point
    assign gt = !occupied || (own_key > new_key);

    // insert shifts toward the tail, pop shifts toward the head
    always_comb
    begin
        part_next = part_reg;
        if (ctrl.ins)
        begin
            if (prev_gt)
                part_next = prev_part;
            else if (gt)
                part_next = new_part;
        end
        else if (ctrl.pop)
        begin
            part_next = next_part;
        end
    end

    always_ff @(posedge clk)
    begin
        part_reg <= part_next;
    end

    assign part = part_reg;

endmodule

// ===== hdl/fpsc_chain.sv =====
// row of cells holding the loaded partitions in stable ascending key order
`timescale 1ns / 1ps

module fpsc_chain
    import fpsc_pkg::*;
#(
    parameter int N       = 32,
    parameter int CNT_W   = 6,
    parameter bit BY_SIZE = 1'b0
)
(
    input  logic             clk,
    input  chain_ctrl_t      ctrl,
    input  logic [CNT_W-1:0] count,
    input  part_t            new_part,
    output part_t            head
);

    part_t cell_part [N];
    logic  cell_gt   [N];

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_cell
            part_t prev_p;
            part_t next_p;
            logic  prev_g;

            // neighbor links, the ends see nothing
            if (i == 0)
            begin : g_first
                assign prev_p = '0;
                assign prev_g = 1'b0;
            end
            else
            begin : g_mid
                assign prev_p = cell_part[i-1];
                assign prev_g = cell_gt[i-1];
            end

            if (i == N - 1)
            begin : g_last
                assign next_p = '0;
            end
            else
            begin : g_inner
                assign next_p = cell_part[i+1];
            end

            fpsc_cell #(
                .BY_SIZE (BY_SIZE)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .occupied  (count > CNT_W'(i)),
                .new_part  (new_part),
                .prev_part (prev_p),
                .prev_gt   (prev_g),
                .next_part (next_p),
                .part      (cell_part[i]),
                .gt        (cell_gt[i])
            );
        end
    endgenerate

    assign head = cell_part[0];

endmodule

// ===== hdl/fpsc_emit.sv =====
// emit stage: coalesces adjacent partitions and drives the result word
`timescale 1ns / 1ps

module fpsc_emit
    import fpsc_pkg::*;
#(
    parameter int SUM_W = 37
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  emit_ctrl_t        ctrl,
    input  part_t             head,
    input  logic              ovf,
    output logic              result_valid,
    output logic [ID_W-1:0]   out_id,
    output logic [ADDR_W-1:0] out_addr,
    output logic [SIZE_W-1:0] out_size,
    output logic              out_last,
    output logic              overflow
);

    logic [ID_W-1:0]   grp_id_reg,   grp_id_next;
    logic [ADDR_W-1:0] grp_addr_reg, grp_addr_next;
    logic [SUM_W-1:0]  grp_size_reg, grp_size_next;
    logic              valid_reg,    valid_next;
    logic [ID_W-1:0]   id_reg,       id_next;
    logic [ADDR_W-1:0] addr_reg,     addr_next;
    logic [SIZE_W-1:0] size_reg,     size_next;
    logic              last_reg,     last_next;
    logic              ovf_reg,      ovf_next;
    logic [SUM_W:0]    grp_end;
    logic              adjacent;
    logic [SIZE_W-1:0] grp_size_sat;

    // exact end of the running group, no wrap
    assign grp_end  = (SUM_W+1)'(grp_addr_reg) + (SUM_W+1)'(grp_size_reg);
    assign adjacent = grp_end == (SUM_W+1)'(head.addr);

    // saturate the grown size on output
    assign grp_size_sat = (grp_size_reg[SUM_W-1:SIZE_W] != '0) ? '1
                                                                : grp_size_reg[SIZE_W-1:0];

    always_comb
    begin
        grp_id_next   = grp_id_reg;
        grp_addr_next = grp_addr_reg;
        grp_size_next = grp_size_reg;
        valid_next    = 1'b0;
        id_next       = id_reg;
        addr_next     = addr_reg;
        size_next     = size_reg;
        last_next     = last_reg;
        ovf_next      = ovf_reg;
        if (ctrl.flush)
        begin
            // close the final group
            valid_next = 1'b1;
            id_next    = grp_id_reg;
            addr_next  = grp_addr_reg;
            size_next  = grp_size_sat;
            last_next  = 1'b1;
            ovf_next   = ovf;
        end
        else if (ctrl.pop && !ctrl.merge_mode)
        begin
            // plain sorted output
            valid_next = 1'b1;
            id_next    = head.id;
            addr_next  = head.addr;
            size_next  = head.size;
            last_next  = ctrl.last_pop;
            ovf_next   = ovf;
        end
        else if (ctrl.pop)
        begin
            if (!ctrl.first && adjacent)
            begin
                grp_size_next = grp_size_reg + SUM_W'(head.size);
            end
            else
            begin
                // emit the previous group unless this is the first entry
                if (!ctrl.first)
                begin
                    valid_next = 1'b1;
                    id_next    = grp_id_reg;
                    addr_next  = grp_addr_reg;
                    size_next  = grp_size_sat;
                    last_next  = 1'b0;
                    ovf_next   = ovf;
                end
                grp_id_next   = head.id;
                grp_addr_next = head.addr;
                grp_size_next = SUM_W'(head.size);
            end
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // group and result payload
    always_ff @(posedge clk)
    begin
        grp_id_reg   <= grp_id_next;
        grp_addr_reg <= grp_addr_next;
        grp_size_reg <= grp_size_next;
        id_reg       <= id_next;
        addr_reg     <= addr_next;
        size_reg     <= size_next;
        last_reg     <= last_next;
        ovf_reg      <= ovf_next;
    end

    assign result_valid = valid_reg;
    assign out_id       = id_reg;
    assign out_addr     = addr_reg;
    assign out_size     = size_reg;
    assign out_last     = last_reg;
    assign overflow     = ovf_reg;

endmodule

// ===== hdl/free_partition_sort_coalesce.sv =====
// top level of the free partition sort and coalesce block
`timescale 1ns / 1ps

// Loads one free partition per cycle while busy is low: two rows of MAX_PARTS
// compare-and-shift cells insert it at once into an address order and a size
// order, both stable. The word marked final_item is loaded like any other and
// then starts the output: busy stays high while the chosen row shifts out
// one entry a cycle, and with merge on also while the last group is closed.
// Results appear on result_valid for one cycle each and cannot be held off.
// With merge off the first result goes through the state and output registers;
// with merge on a group waits for a later entry or the flush to close it,
// and folded entries leave gaps between strobes. Words beyond MAX_PARTS
// are dropped and reported by overflow on every result of the list.
// Configuration writes are taken in any cycle (cfg_ready is always high); the
// order and merge choice is taken from the registers at the final word.
module free_partition_sort_coalesce
    import fpsc_pkg::*;
#(
    parameter int MAX_PARTS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [ID_W-1:0]      part_id,
    input  logic [ADDR_W-1:0]    start_addr,
    input  logic [SIZE_W-1:0]    part_size,
    input  logic                 final_item,
    output logic                 result_valid,
    output logic [ID_W-1:0]      out_id,
    output logic [ADDR_W-1:0]    out_addr,
    output logic [SIZE_W-1:0]    out_size,
    output logic                 out_last,
    output logic                 overflow,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data
);

    localparam int CNT_W = $clog2(MAX_PARTS + 1);
    localparam int SUM_W = SIZE_W + $clog2(MAX_PARTS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EMIT  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]       state_reg,   state_next;
    logic [CNT_W-1:0] count_reg,   count_next;
    logic             dropped_reg, dropped_next;
    logic             first_reg,   first_next;
    logic             ovf_reg,     ovf_next;
    logic             by_size_reg, by_size_next;
    logic             merge_reg,   merge_next;
    logic             sort_by_size_reg;
    logic             merge_enable_reg;
    logic             accept;
    logic             full;
    logic             last_pop;
    chain_ctrl_t      chain_ctrl;
    emit_ctrl_t       emit_ctrl;
    part_t            new_part;
    part_t            addr_head;
    part_t            size_head;

    assign accept   = start && !busy;
    assign full     = count_reg == CNT_W'(MAX_PARTS);
    assign last_pop = count_reg == CNT_W'(1);
    assign busy     = state_reg != ST_IDLE;
    assign new_part = '{id: part_id, addr: start_addr, size: part_size};

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sort_by_size_reg <= 1'b0;
            merge_enable_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_SORT_BY_SIZE)
                sort_by_size_reg <= cfg_data;
            else if (cfg_index == REG_MERGE_ENABLE)
                merge_enable_reg <= cfg_data;
        end
    end

    // load and emit sequencer
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        first_next   = first_reg;
        ovf_next     = ovf_reg;
        by_size_next = by_size_reg;
        merge_next   = merge_reg;
        chain_ctrl   = '{ins: 1'b0, pop: 1'b0};
        emit_ctrl    = '{pop: 1'b0, first: first_reg, last_pop: last_pop,
                         merge_mode: merge_reg, flush: 1'b0};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        chain_ctrl.ins = 1'b1;
                        count_next     = count_reg + CNT_W'(1);
                    end
                    if (final_item)
                    begin
                        state_next   = ST_EMIT;
                        first_next   = 1'b1;
                        ovf_next     = dropped_reg || full;
                        dropped_next = 1'b0;
                        merge_next   = merge_enable_reg;
                        by_size_next = !merge_enable_reg && sort_by_size_reg;
                    end
                end
            end
            ST_EMIT:
            begin
                chain_ctrl.pop = 1'b1;
                emit_ctrl.pop  = 1'b1;
                count_next     = count_reg - CNT_W'(1);
                first_next     = 1'b0;
                if (last_pop)
                    state_next = merge_reg ? ST_FLUSH : ST_IDLE;
            end
            ST_FLUSH:
            begin
                emit_ctrl.flush = 1'b1;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            first_reg   <= 1'b0;
            ovf_reg     <= 1'b0;
            by_size_reg <= 1'b0;
            merge_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            first_reg   <= first_next;
            ovf_reg     <= ovf_next;
            by_size_reg <= by_size_next;
            merge_reg   <= merge_next;
        end
    end

    // address-ordered row
    fpsc_chain #(
        .N       (MAX_PARTS),
        .CNT_W   (CNT_W),
        .BY_SIZE (1'b0)
    ) u_addr_chain (
        .clk      (clk),
        .ctrl     (chain_ctrl),
        .count    (count_reg),
        .new_part (new_part),
        .head     (addr_head)
    );

    // size-ordered row
    fpsc_chain #(
        .N       (MAX_PARTS),
        .CNT_W   (CNT_W),
        .BY_SIZE (1'b1)
    ) u_size_chain (
        .clk      (clk),
        .ctrl     (chain_ctrl),
        .count    (count_reg),
        .new_part (new_part),
        .head     (size_head)
    );

    // output and coalesce stage
    fpsc_emit #(
        .SUM_W (SUM_W)
    ) u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (emit_ctrl),
        .head         (by_size_reg ? size_head : addr_head),
        .ovf          (ovf_reg),
        .result_valid (result_valid),
        .out_id       (out_id),
        .out_addr     (out_addr),
        .out_size     (out_size),
        .out_last     (out_last),
        .overflow     (overflow)
    );

endmodule

// ===== hdl/fpsc_checker.sv =====
// port-level checker of the free partition sort and coalesce block, with its bind
`timescale 1ns / 1ps

module fpsc_checker
    import fpsc_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic final_item,
    input logic result_valid,
    input logic out_last,
    input logic overflow
);

    // a final word always starts an output phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && final_item) |=> busy)
    else $error("final word did not raise busy");

    // the last word of a list is never followed at once by another result
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && out_last) |=> !result_valid)
    else $error("result right after the last word");

    // overflow keeps its value inside one emitted list
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !out_last) |=> $stable(overflow))
    else $error("overflow changed within a list");

    // results come only out of an output phase
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (busy || $past(busy)))
    else $error("result outside an output phase");

endmodule

bind free_partition_sort_coalesce fpsc_checker u_fpsc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .final_item   (final_item),
    .result_valid (result_valid),
    .out_last     (out_last),
    .overflow     (overflow)
);

// ===== bench/tb_free_partition_sort_coalesce.sv =====
// self-checking testbench of the free partition sort and coalesce block
`timescale 1ns / 1ps

module tb_free_partition_sort_coalesce;

    import fpsc_pkg::*;

    localparam int MAX_PARTS = 32;
    localparam int RANDOM_WORDS = 410;

    // indexes that select no register, writes to them must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    // one load word as sent to the block
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
        logic              fin;
    } part_word_t;

    // one emitted partition
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
        logic              last;
        logic              ovf;
    } free_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [ID_W-1:0]      part_id;
    logic [ADDR_W-1:0]    start_addr;
    logic [SIZE_W-1:0]    part_size;
    logic                 final_item;
    logic                 result_valid;
    logic [ID_W-1:0]      out_id;
    logic [ADDR_W-1:0]    out_addr;
    logic [SIZE_W-1:0]    out_size;
    logic                 out_last;
    logic                 overflow;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic                 cfg_data;

    // words waiting for the driver and results waiting for the block
    part_word_t   pending_words [$];
    free_result_t expected_parts [$];

    // predictor copy of the store and the registers
    logic [ID_W-1:0]   held_id   [MAX_PARTS];
    logic [ADDR_W-1:0] held_addr [MAX_PARTS];
    logic [SIZE_W-1:0] held_size [MAX_PARTS];
    int                held_count = 0;
    logic              dropped = 1'b0;
    logic              order_by_size = 1'b0;
    logic              coalesce_on = 1'b1;

    // driver state
    part_word_t cur_word = '0;
    bit         drive_on = 1'b0;
    bit         word_taken = 1'b0;
    int         gap_left = 0;
    int         burst_left = 0;
    int         pick;

    // bookkeeping
    int           words_queued = 0;
    int           words_done = 0;
    int           random_words = 0;
    int           lists_done = 0;
    int           overflow_lists = 0;
    int           folds = 0;
    int           results_seen = 0;
    int           cfg_writes = 0;
    int           bad_results = 0;
    free_result_t want;
    part_word_t   seen_word;

    free_partition_sort_coalesce #(
        .MAX_PARTS (MAX_PARTS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .part_id      (part_id),
        .start_addr   (start_addr),
        .part_size    (part_size),
        .final_item   (final_item),
        .result_valid (result_valid),
        .out_id       (out_id),
        .out_addr     (out_addr),
        .out_size     (out_size),
        .out_last     (out_last),
        .overflow     (overflow),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // queue one emitted partition, size saturated at 32 bits
    task automatic push_expected(input logic [ID_W-1:0] id, input logic [ADDR_W-1:0] addr,
                                 input logic [63:0] sum, input logic last);
        free_result_t r;
        r.id   = id;
        r.addr = addr;
        r.size = (sum > 64'hFFFF_FFFF) ? '1 : sum[SIZE_W-1:0];
        r.last = last;
        r.ovf  = dropped;
        expected_parts.push_back(r);
    endtask

    // store one word; on the final word sort, coalesce and emit the list
    task automatic load_partition(input part_word_t w);
        int          order_idx [MAX_PARTS];
        int          n;
        int          i;
        int          j;
        int          e;
        logic        by_size;
        logic [ID_W-1:0]   grp_id;
        logic [ADDR_W-1:0] grp_addr;
        logic [63:0]       grp_size;
        if (held_count < MAX_PARTS)
        begin
            held_id[held_count]   = w.id;
            held_addr[held_count] = w.addr;
            held_size[held_count] = w.size;
            held_count++;
        end
        else
            dropped = 1'b1;
        if (!w.fin)
            return;
        n = held_count;
        by_size = coalesce_on ? 1'b0 : order_by_size;
        // stable insertion sort of the held entries
        for (i = 0; i < n; i++)
        begin
            j = i;
            while (j > 0 && ((by_size ? held_size[i] : held_addr[i])
                   < (by_size ? held_size[order_idx[j-1]] : held_addr[order_idx[j-1]])))
            begin
                order_idx[j] = order_idx[j-1];
                j--;
            end
            order_idx[j] = i;
        end
        lists_done++;
        if (dropped)
            overflow_lists++;
        if (!coalesce_on)
        begin
            for (i = 0; i < n; i++)
            begin
                e = order_idx[i];
                push_expected(held_id[e], held_addr[e], {32'b0, held_size[e]}, i == n - 1);
            end
        end
        else if (n > 0)
        begin
            // fold each entry that starts exactly at the running end, no wrap
            e = order_idx[0];
            grp_id   = held_id[e];
            grp_addr = held_addr[e];
            grp_size = {32'b0, held_size[e]};
            for (i = 1; i < n; i++)
            begin
                e = order_idx[i];
                if ({32'b0, grp_addr} + grp_size == {32'b0, held_addr[e]})
                begin
                    grp_size += held_size[e];
                    folds++;
                end
                else
                begin
                    push_expected(grp_id, grp_addr, grp_size, 1'b0);
                    grp_id   = held_id[e];
                    grp_addr = held_addr[e];
                    grp_size = {32'b0, held_size[e]};
                end
            end
            push_expected(grp_id, grp_addr, grp_size, 1'b1);
        end
        held_count = 0;
        dropped = 1'b0;
    endtask

    // result check, register writes and word acceptance
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
            begin
                results_seen++;
                if (expected_parts.size() == 0)
                begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("%0t: unexpected result id %h addr %h size %h last %b ovf %b",
                                 $time, out_id, out_addr, out_size, out_last, overflow);
                end
                else
                begin
                    want = expected_parts.pop_front();
                    if (out_id !== want.id || out_addr !== want.addr || out_size !== want.size
                        || out_last !== want.last || overflow !== want.ovf)
                    begin
                        bad_results++;
                        if (bad_results <= 10)
                            $display({"%0t: mismatch, expected id %h addr %h size %h last %b ",
                                      "ovf %b, got id %h addr %h size %h last %b ovf %b"},
                                     $time, want.id, want.addr, want.size, want.last, want.ovf,
                                     out_id, out_addr, out_size, out_last, overflow);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                cfg_writes++;
                case (cfg_index)
                    REG_SORT_BY_SIZE: order_by_size = cfg_data;
                    REG_MERGE_ENABLE: coalesce_on = cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                seen_word.id   = part_id;
                seen_word.addr = start_addr;
                seen_word.size = part_size;
                seen_word.fin  = final_item;
                load_partition(seen_word);
                words_done++;
                word_taken = 1'b1;
            end
        end
    end

    // word driver with random gaps and occasional back-to-back bursts
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            if (word_taken)
            begin
                word_taken = 1'b0;
                drive_on = 1'b0;
                if (burst_left > 0)
                begin
                    burst_left--;
                    gap_left = 0;
                end
                else
                begin
                    pick = $urandom_range(99);
                    if (pick < 50)
                        gap_left = 0;
                    else if (pick < 85)
                        gap_left = $urandom_range(3, 1);
                    else if (pick < 95)
                        gap_left = $urandom_range(10, 4);
                    else
                        gap_left = $urandom_range(40, 20);
                    if ($urandom_range(19) == 0)
                        burst_left = $urandom_range(30, 8);
                end
            end
            if (!drive_on)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_words.size() > 0)
                begin
                    cur_word = pending_words.pop_front();
                    drive_on = 1'b1;
                end
            end
            start      <= drive_on;
            part_id    <= cur_word.id;
            start_addr <= cur_word.addr;
            part_size  <= cur_word.size;
            final_item <= cur_word.fin;
        end
    end

    // queue one word for the driver
    task automatic add_word(input logic [ID_W-1:0] id, input logic [ADDR_W-1:0] addr,
                            input logic [SIZE_W-1:0] size, input logic fin);
        part_word_t w;
        w.id   = id;
        w.addr = addr;
        w.size = size;
        w.fin  = fin;
        pending_words.push_back(w);
        words_queued++;
    endtask

    // one register write over the config channel
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // wait until every word is taken and every result is back, bounded
    task automatic wait_idle();
        int waited;
        waited = 0;
        do
        begin
            @(negedge clk);
            waited++;
        end
        while (!(words_done == words_queued && expected_parts.size() == 0 && !busy)
               && waited < 5000);
        repeat (8) @(negedge clk);
    endtask

    // one random list: contiguous runs, full-range values or crowded small keys
    task automatic gen_list();
        part_word_t  pw [$];
        part_word_t  tmp;
        int          len;
        int          style;
        int          k;
        int          s;
        logic [ADDR_W-1:0] next_addr;
        pick = $urandom_range(99);
        if (pick < 70)
            len = $urandom_range(8, 1);
        else if (pick < 90)
            len = $urandom_range(MAX_PARTS, 9);
        else
            len = $urandom_range(MAX_PARTS + 8, MAX_PARTS + 1);
        pick = $urandom_range(99);
        style = (pick < 50) ? 0 : (pick < 75) ? 1 : 2;
        next_addr = ($urandom_range(1) == 0) ? $urandom_range(15) : $urandom;
        for (k = 0; k < len; k++)
        begin
            tmp.id = ID_W'($urandom);
            case (style)
                0:
                begin
                    tmp.size = ($urandom_range(9) == 0) ? $urandom : $urandom_range(255);
                    if ($urandom_range(4) == 0)
                        next_addr = next_addr + $urandom_range(16, 1);
                    tmp.addr = next_addr;
                    next_addr = next_addr + tmp.size;
                end
                1:
                begin
                    tmp.addr = $urandom;
                    tmp.size = $urandom;
                end
                default:
                begin
                    tmp.addr = $urandom_range(15);
                    tmp.size = $urandom_range(7);
                end
            endcase
            tmp.fin = 1'b0;
            pw.push_back(tmp);
        end
        // shuffle most lists so sorting has work to do
        if ($urandom_range(3) != 0)
        begin
            for (k = len - 1; k > 0; k--)
            begin
                s = $urandom_range(k);
                tmp = pw[k];
                pw[k] = pw[s];
                pw[s] = tmp;
            end
        end
        pw[len-1].fin = 1'b1;
        foreach (pw[k])
            add_word(pw[k].id, pw[k].addr, pw[k].size, pw[k].fin);
        random_words += len;
    endtask

    // reset, directed lists, then random phases
    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        part_id    = '0;
        start_addr = '0;
        part_size  = '0;
        final_item = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_SORT_BY_SIZE;
        cfg_data   = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset registers: coalescing by address
        // chain of adjacent entries incl. a zero size one and an equal start
        add_word(16'hFFFF, 32'h0000_1000, 32'h0000_0100, 1'b0);
        add_word(16'h0001, 32'h0000_0000, 32'h0000_1000, 1'b0);
        add_word(16'h0002, 32'h0000_1100, 32'h0000_0000, 1'b0);
        add_word(16'h0003, 32'h0000_1100, 32'h0000_0010, 1'b0);
        add_word(16'h0004, 32'h0000_2000, 32'h0000_0005, 1'b1);
        // merged size past 32 bits saturates
        add_word(16'h0005, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        add_word(16'h0006, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        // entry reaching past the top address does not merge with the entry at its wrapped end
        add_word(16'h0007, 32'hFFFF_FFF0, 32'h0000_0020, 1'b0);
        add_word(16'h0008, 32'h0000_0010, 32'h0000_0004, 1'b1);
        // single word list
        add_word(16'h0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
        wait_idle();

        // merge off, order by address with ties; spare indexes ignored
        write_reg(REG_MERGE_ENABLE, 1'b0);
        write_reg(REG_SORT_BY_SIZE, 1'b0);
        write_reg(REG_SPARE_2, 1'b1);
        write_reg(REG_SPARE_3, 1'b1);
        add_word(16'h0010, 32'h0000_0300, 32'h0000_0001, 1'b0);
        add_word(16'h0011, 32'h0000_0100, 32'h0000_0009, 1'b0);
        add_word(16'h0012, 32'h0000_0300, 32'h0000_0000, 1'b0);
        add_word(16'h0013, 32'h0000_0109, 32'h0000_0002, 1'b1);
        wait_idle();

        // merge off, order by size with ties
        write_reg(REG_SORT_BY_SIZE, 1'b1);
        add_word(16'h0020, 32'h0000_0000, 32'h0000_0050, 1'b0);
        add_word(16'h0021, 32'h0000_0010, 32'h0000_0020, 1'b0);
        add_word(16'h0022, 32'h0000_0020, 32'h0000_0050, 1'b0);
        add_word(16'h0023, 32'hFFFF_0000, 32'h0000_0000, 1'b1);
        wait_idle();

        // merge on overrides order by size
        write_reg(REG_MERGE_ENABLE, 1'b1);
        add_word(16'h0030, 32'h0000_0040, 32'h0000_0040, 1'b0);
        add_word(16'h0031, 32'h0000_0000, 32'h0000_0040, 1'b0);
        add_word(16'h0032, 32'h0000_0080, 32'hFFFF_FFFF, 1'b1);
        wait_idle();

        // random phases, each with fresh register values
        while (random_words < RANDOM_WORDS)
        begin
            write_reg(REG_SORT_BY_SIZE, 1'($urandom_range(1)));
            write_reg(REG_MERGE_ENABLE, 1'($urandom_range(1)));
            if ($urandom_range(3) == 0)
                write_reg(($urandom_range(1) == 0) ? REG_SPARE_2 : REG_SPARE_3,
                          1'($urandom_range(1)));
            repeat ($urandom_range(4, 1))
                gen_list();
            wait_idle();
        end

        $display("covered %0d words in %0d lists, %0d lists past capacity, %0d config writes",
                 words_done, lists_done, overflow_lists, cfg_writes);
        $display("checked %0d results, %0d partitions folded by coalescing",
                 results_seen, folds);
        if (expected_parts.size() != 0)
        begin
            $display("%0d expected results never arrived", expected_parts.size());
            bad_results += expected_parts.size();
        end
        if (bad_results == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
